>>> rtl/ssr_pkg.sv
package ssr_pkg;

  // Field widths of the channel beats.
  localparam int OP_W     = 3;
  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 11;
  localparam int RANK_W   = 5;
  localparam int CNT_W    = 8;
  localparam int ST_W     = 2;
  localparam int CH_W     = 5;

  // Widest sum of an average: 255 samples of 12 bits.
  localparam int SUM_W = 20;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd1;
  localparam logic [OP_W-1:0] OP_RDNEXT = 3'd2;
  localparam logic [OP_W-1:0] OP_SKIP   = 3'd3;
  localparam logic [OP_W-1:0] OP_RDPOS  = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd5;
  localparam logic [OP_W-1:0] OP_AVG    = 3'd6;
  localparam logic [OP_W-1:0] OP_RDBACK = 3'd7;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS  = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_RANK = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO_CNT = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    position;
    logic                from_latest;
    logic [RANK_W-1:0]   rank;
    logic [POS_W-1:0]    amount;
    logic [CNT_W-1:0]    avg_count;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [RANK_W-1:0]   out_rank;
    logic [POS_W-1:0]    out_position;
    logic [POS_W-1:0]    unread;
    logic [ST_W-1:0]     status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic load;
    logic exec;
    logic post;
    logic rd;
    logic get;
    logic quot;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;
    logic            cnt_zero;
    logic            clr_last;
    logic            div_done;
    logic            acc_last;
    logic            out_free;
  } sts_t;

endpackage

>>> rtl/ssr_div.sv
module ssr_div import ssr_pkg::*; #(
  parameter int NW = 20,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] d_r;
  logic [DW:0]   remsh;
  logic          fits;
  logic [DW:0]   rem_sub;

  // One quotient bit per cycle, restoring long division.
  always_comb begin
    remsh   = {rem_r, n_r[NW-1]};
    fits    = remsh >= {1'b0, d_r};
    rem_sub = remsh - {1'b0, d_r};
  end

  // Control: busy while bits remain, done holds until the next start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[NW-2:0], 1'b0};
      q_r   <= {q_r[NW-2:0], fits};
      rem_r <= fits ? rem_sub[DW-1:0] : remsh[DW-1:0];
    end
  end

  assign quo  = q_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

>>> rtl/ssr_ctrl.sv
module ssr_ctrl import ssr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_EXEC  = 10'b0000000100,
    S_MODW  = 10'b0000001000,
    S_POST  = 10'b0000010000,
    S_READ  = 10'b0000100000,
    S_GET   = 10'b0001000000,
    S_AVGW  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (sts.op == OP_PUSH) state_nxt = S_IDLE;
        else if (sts.op == OP_COUNT || sts.err) state_nxt = S_FIN;
        else state_nxt = S_MODW;
      end
      S_MODW: begin
        if (sts.div_done) state_nxt = S_POST;
      end
      S_POST: begin
        cmd.post = 1'b1;
        priority if (sts.op == OP_SKIP || sts.op == OP_FIND) state_nxt = S_FIN;
        else if (sts.op == OP_AVG && sts.cnt_zero) state_nxt = S_FIN;
        else state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_GET;
      end
      S_GET: begin
        cmd.get = 1'b1;
        priority if (sts.op != OP_AVG) state_nxt = S_FIN;
        else if (sts.acc_last) state_nxt = S_AVGW;
        else state_nxt = S_READ;
      end
      S_AVGW: begin
        if (sts.div_done) begin
          cmd.quot  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> rtl/ssr_dp.sv
module ssr_dp import ssr_pkg::*; #(
  parameter int SCANS        = 128,
  parameter int MAX_CHANNELS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  in_t             in_data,
  input  logic            cfg_we,
  input  logic [CH_W-1:0] cfg_wdata,
  input  cmd_t            cmd,
  output sts_t            sts,
  output logic            out_valid,
  input  logic            out_stall,
  output out_t            out_data
);

  localparam int DEPTH  = MAX_CHANNELS * SCANS;
  localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW     = (IW > POS_W) ? IW : POS_W;
  localparam int SZW    = AW + 1;
  localparam int ZW     = AW + 2;
  localparam int NW     = (SUM_W > SZW) ? SUM_W : SZW;
  localparam int RST_CH = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;

  // Sample store and its registered read port.
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_r;

  // Ring state and latched beat.
  logic [CH_W-1:0]  ch_r;
  logic [SZW-1:0]   size_r;
  logic [AW-1:0]    lw_r, lr_r;
  logic [IW-1:0]    clr_r;
  in_t              item_r;
  logic [ZW-1:0]    z_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] i_r;
  out_t             res_r;
  out_t             out_r;
  logic             out_valid_r;

  // Combinational helpers.
  logic [AW-1:0]    lw_inc, lr_inc;
  logic [SZW-1:0]   unread_c;
  logic [AW-1:0]    start_c;
  logic [ZW-1:0]    z0, z0w, z1, z1w, zd, zdw;
  logic             bad_pos, bad_rank, err_c;
  logic [RANK_W-1:0] r0;
  logic [SUM_W-1:0] sum_nxt;
  logic [CH_W-1:0]  ch_nxt;
  logic [SZW-1:0]   size_nxt;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  logic [SAMPLE_W-1:0] mem_wd;

  // Shared divider: rank and wrap remainders, and the average quotient.
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [SZW-1:0] div_den;
  logic [NW-1:0] div_quo;
  logic [SZW-1:0] div_rem;
  logic          div_done;

  ssr_div #(.NW(NW), .DW(SZW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  // Pointer steps, unread count and backward position arithmetic.
  always_comb begin
    lw_inc   = (SZW'(lw_r) == size_r - 1'b1) ? '0 : lw_r + 1'b1;
    lr_inc   = (SZW'(lr_r) == size_r - 1'b1) ? '0 : lr_r + 1'b1;
    unread_c = (lw_r >= lr_r) ? SZW'(lw_r - lr_r) : size_r - SZW'(lr_r) + SZW'(lw_r);

    start_c = ((item_r.op == OP_FIND || item_r.op == OP_AVG) && item_r.from_latest)
              ? lw_r : AW'(item_r.position);
    z0  = ZW'(start_c) - ZW'(item_r.amount);
    z0w = z0[ZW-1] ? z0 + ZW'(size_r) : z0;

    bad_rank = (item_r.rank == '0) || (item_r.rank > RANK_W'(ch_r));
    if (item_r.op == OP_RDPOS) bad_pos = SZW'(item_r.position) >= size_r;
    else bad_pos = z0w[ZW-1] || (z0w >= ZW'(size_r));

    unique case (item_r.op)
      OP_RDPOS, OP_RDBACK: err_c = bad_pos;
      OP_FIND, OP_AVG:     err_c = bad_pos || bad_rank;
      default:             err_c = 1'b0;
    endcase

    // Newest position of the requested rank at or behind z.
    r0 = RANK_W'(div_rem) + 1'b1;
    if (r0 == item_r.rank) z1 = z_r;
    else if (r0 > item_r.rank) z1 = z_r - ZW'(r0) + ZW'(item_r.rank);
    else z1 = z_r + ZW'(item_r.rank) - ZW'(r0) - ZW'(ch_r);
    z1w = z1[ZW-1] ? z1 + ZW'(size_r) : z1;

    // One scan back for the averaging walk.
    zd  = z_r - ZW'(ch_r);
    zdw = zd[ZW-1] ? zd + ZW'(size_r) : zd;

    sum_nxt = sum_r + SUM_W'(rdata_r);
  end

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = SZW'(ch_r);
    if (cmd.exec && !err_c) begin
      unique case (item_r.op)
        OP_RDNEXT: begin
          div_start = 1'b1;
          div_num   = NW'(lr_inc);
        end
        OP_SKIP: begin
          div_start = 1'b1;
          div_num   = NW'(lr_r) + NW'(item_r.amount);
          div_den   = size_r;
        end
        OP_RDPOS: begin
          div_start = 1'b1;
          div_num   = NW'(item_r.position);
        end
        OP_FIND, OP_AVG, OP_RDBACK: begin
          div_start = 1'b1;
          div_num   = NW'(z0w[AW-1:0]);
        end
        default: div_start = 1'b0;
      endcase
    end else if (cmd.get && item_r.op == OP_AVG && i_r == CNT_W'(1)) begin
      div_start = 1'b1;
      div_num   = NW'(sum_nxt);
      div_den   = SZW'(item_r.avg_count);
    end
  end

  // Channel count clamp and ring size for a register write.
  always_comb begin
    ch_nxt = cfg_wdata;
    if (ch_nxt == '0) ch_nxt = CH_W'(1);
    if (ch_nxt > CH_W'(MAX_CHANNELS)) ch_nxt = CH_W'(MAX_CHANNELS);
    size_nxt = SZW'(ch_nxt) * SZW'(SCANS);
  end

  // Store write: the clearing pass first, then pushes.
  always_comb begin
    mem_we = cmd.clr || (cmd.exec && item_r.op == OP_PUSH);
    mem_wa = cmd.clr ? clr_r : lw_inc[IW-1:0];
    mem_wd = cmd.clr ? '0 : item_r.sample;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) rdata_r <= mem[z_r[IW-1:0]];
  end

  // Control registers: clear sweep, pointers, channel count, output flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      ch_r        <= CH_W'(RST_CH);
      size_r      <= SZW'(RST_CH * SCANS);
      lw_r        <= AW'(RST_CH * SCANS - 1);
      lr_r        <= AW'(RST_CH * SCANS - 1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.exec && item_r.op == OP_PUSH) lw_r <= lw_inc;
      if (cmd.exec && item_r.op == OP_RDNEXT) lr_r <= lr_inc;
      if (cmd.post && item_r.op == OP_SKIP) lr_r <= div_rem[AW-1:0];
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        ch_r   <= ch_nxt;
        size_r <= size_nxt;
        lw_r   <= AW'(size_nxt - 1'b1);
        lr_r   <= AW'(size_nxt - 1'b1);
      end
    end
  end

  // Work registers and the result being built.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      res_r  <= '0;
    end
    if (cmd.exec) begin
      unique case (item_r.op)
        OP_COUNT:  res_r.unread <= unread_c[POS_W-1:0];
        OP_RDNEXT: z_r <= ZW'(lr_inc);
        OP_RDPOS:  z_r <= ZW'(item_r.position);
        OP_FIND, OP_AVG, OP_RDBACK: z_r <= z0w;
        default:   z_r <= z_r;
      endcase
      if (err_c) res_r.status <= (bad_pos ? ST_BAD_POS : ST_BAD_RANK);
    end
    if (cmd.post) begin
      unique case (item_r.op)
        OP_RDNEXT, OP_RDPOS, OP_RDBACK: res_r.out_rank <= r0;
        OP_FIND: res_r.out_position <= z1w[POS_W-1:0];
        OP_AVG: begin
          if (item_r.avg_count == '0) res_r.status <= ST_ZERO_CNT;
          z_r   <= z1w;
          sum_r <= '0;
          i_r   <= item_r.avg_count;
        end
        default: res_r <= res_r;
      endcase
    end
    if (cmd.get) begin
      if (item_r.op == OP_AVG) begin
        sum_r <= sum_nxt;
        i_r   <= i_r - 1'b1;
        z_r   <= zdw;
      end else begin
        res_r.value <= rdata_r;
      end
    end
    if (cmd.quot) res_r.value <= div_quo[SAMPLE_W-1:0];
    if (cmd.emit) out_r <= res_r;
  end

  always_comb begin
    sts          = '0;
    sts.op       = item_r.op;
    sts.err      = err_c;
    sts.cnt_zero = (item_r.avg_count == '0);
    sts.clr_last = (clr_r == IW'(DEPTH - 1));
    sts.div_done = div_done;
    sts.acc_last = (i_r == CNT_W'(1));
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/scan_sample_ring_with_rank_average.sv
// Sample ring of channels x SCANS 12-bit entries with rank search and rank
// averaging. After reset the block sweeps the store to zero, one entry per
// cycle, and holds in_stall high meanwhile; the channels register may be
// written at any idle time and restarts both pointers. One beat is worked at
// a time. Everything but a push, a count or a rejected query runs through
// one shared restoring divider that yields one bit per cycle (20 quotient
// bits at the defaults); a rank average uses it twice, for the rank and then
// for the quotient, the averaging walk reading the store once per sample over
// its single read port. Results sit in an output register, so a new beat is
// taken while the last result waits.
module scan_sample_ring_with_rank_average import ssr_pkg::*; #(
  parameter int SCANS        = 128,
  parameter int MAX_CHANNELS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_t            out_data,
  input  logic            cfg_we,
  input  logic [CH_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssr_dp #(.SCANS(SCANS), .MAX_CHANNELS(MAX_CHANNELS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An accepted beat always closes the input until it is worked.
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a beat was taken");

  // A result handed to the output register shows up as valid.
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

  // The controller issues at most one work step per cycle.
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr, cmd.load, cmd.exec, cmd.post, cmd.rd, cmd.get, cmd.quot,
              cmd.emit}))
    else $error("overlapping datapath commands");

endmodule

>>> tb/sv/ssr_checker.sv
// Watches both channels and the register port of the sample ring, predicts
// every result beat and compares it with what the block delivers.
module ssr_checker import ssr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  in_t             in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  out_t            out_data,
  input  logic            cfg_we,
  input  logic [CH_W-1:0] cfg_wdata,
  output int              fail_count,
  output int              pending
);

  localparam int SCANS = 128;
  localparam int MAX_CH = 16;

  // Private copy of the ring state.
  logic [SAMPLE_W-1:0] ring_mem [0:MAX_CH*SCANS-1];
  int   num_ch;
  int   wr_ptr;
  int   rd_ptr;
  out_t results_due [$];

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int rank_at(input int p);
    return (p % num_ch) + 1;
  endfunction

  // Steps back from the start and finds the newest entry of the wanted rank.
  function automatic logic [ST_W-1:0] seek_rank(input int start, input int back,
                                                input int want, output int hit);
    int ring;
    int z0;
    int r0;
    ring = num_ch * SCANS;
    hit = 0;
    z0 = start - back;
    if (z0 < 0) z0 += ring;
    if (z0 < 0 || z0 >= ring) return ST_BAD_POS;
    if (want == 0 || want > num_ch) return ST_BAD_RANK;
    r0 = rank_at(z0);
    if (r0 == want) hit = z0;
    else if (r0 > want) hit = z0 - r0 + want;
    else hit = z0 + want - r0 - num_ch;
    if (hit < 0) hit += ring;
    return ST_OK;
  endfunction

  // Applies one accepted beat to the state; returns 1 when a result follows.
  function automatic bit ring_step(input in_t b, output out_t r);
    int ring;
    int z;
    int start;
    int sum;
    ring = num_ch * SCANS;
    r = '0;
    start = b.from_latest ? wr_ptr : int'(b.position);
    case (b.op)
      OP_PUSH: begin
        wr_ptr = (wr_ptr + 1) % ring;
        ring_mem[wr_ptr] = b.sample;
        return 1'b0;
      end
      OP_COUNT: begin
        r.unread = POS_W'((wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : ring - rd_ptr + wr_ptr);
      end
      OP_RDNEXT: begin
        rd_ptr = (rd_ptr + 1) % ring;
        r.value = ring_mem[rd_ptr];
        r.out_rank = RANK_W'(rank_at(rd_ptr));
      end
      OP_SKIP: begin
        rd_ptr = (rd_ptr + int'(b.amount)) % ring;
      end
      OP_RDPOS: begin
        if (int'(b.position) >= ring) begin
          r.status = ST_BAD_POS;
        end else begin
          r.value = ring_mem[b.position];
          r.out_rank = RANK_W'(rank_at(int'(b.position)));
        end
      end
      OP_FIND: begin
        r.status = seek_rank(start, int'(b.amount), int'(b.rank), z);
        if (r.status == ST_OK) r.out_position = POS_W'(z);
      end
      OP_AVG: begin
        r.status = seek_rank(start, int'(b.amount), int'(b.rank), z);
        if (r.status == ST_OK && b.avg_count == 0) r.status = ST_ZERO_CNT;
        if (r.status == ST_OK) begin
          sum = int'(ring_mem[z]);
          for (int i = 1; i < int'(b.avg_count); i++) begin
            z -= num_ch;
            if (z < 0) z += ring;
            sum += int'(ring_mem[z]);
          end
          r.value = SAMPLE_W'(sum / int'(b.avg_count));
        end
      end
      default: begin
        z = int'(b.position) - int'(b.amount);
        if (z < 0) z += ring;
        if (z < 0 || z >= ring) begin
          r.status = ST_BAD_POS;
        end else begin
          r.value = ring_mem[z];
          r.out_rank = RANK_W'(rank_at(z));
        end
      end
    endcase
    return 1'b1;
  endfunction

  // Tracks register writes, accepted input beats and result beats.
  always @(posedge clk) begin
    out_t exp_r;
    out_t got;
    if (!rst_n) begin
      foreach (ring_mem[i]) ring_mem[i] = '0;
      num_ch = 3;
      wr_ptr = num_ch * SCANS - 1;
      rd_ptr = wr_ptr;
      results_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        num_ch = (cfg_wdata == 0) ? 1 : (cfg_wdata > MAX_CH) ? MAX_CH : int'(cfg_wdata);
        wr_ptr = num_ch * SCANS - 1;
        rd_ptr = wr_ptr;
      end
      if (in_valid && !in_stall) begin
        if (ring_step(in_data, exp_r)) results_due.push_back(exp_r);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (results_due.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          exp_r = results_due.pop_front();
          if (got.value !== exp_r.value)
            report($sformatf("value %0d, expected %0d", got.value, exp_r.value));
          if (got.out_rank !== exp_r.out_rank)
            report($sformatf("rank %0d, expected %0d", got.out_rank, exp_r.out_rank));
          if (got.out_position !== exp_r.out_position)
            report($sformatf("position %0d, expected %0d",
                             got.out_position, exp_r.out_position));
          if (got.unread !== exp_r.unread)
            report($sformatf("unread %0d, expected %0d", got.unread, exp_r.unread));
          if (got.status !== exp_r.status)
            report($sformatf("status %0d, expected %0d", got.status, exp_r.status));
        end
      end
    end
    pending <= results_due.size();
  end

endmodule

>>> tb/sv/tb.sv
module tb;
  import ssr_pkg::*;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  in_t             in_data;
  logic            out_valid;
  logic            out_stall;
  out_t            out_data;
  logic            cfg_we;
  logic [CH_W-1:0] cfg_wdata;
  int              fail_count;
  int              pending;

  int tx_idle_pct;
  int rx_idle_pct;
  int ch_now;
  int hold_req;
  int hold_seen = 0;
  int hold_left = 0;

  scan_sample_ring_with_rank_average dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  ssr_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog for a hung run.
  initial begin
    #(8 * 3000000);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver side: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Sends one beat, with random gaps ahead of it.
  task automatic send_beat(input in_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits for all results, then for the longest query that may still run.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (600) @(posedge clk);
  endtask

  task automatic write_channels(input int v);
    cfg_we <= 1'b1;
    cfg_wdata <= CH_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    ch_now = (v == 0) ? 1 : (v > 16) ? 16 : v;
  endtask

  function automatic in_t make_beat(input logic [OP_W-1:0] op, input int smp, input int pos,
                                    input bit fl, input int rk, input int amt,
                                    input int cnt);
    in_t b;
    b.op = op;
    b.sample = SAMPLE_W'(smp);
    b.position = POS_W'(pos);
    b.from_latest = fl;
    b.rank = RANK_W'(rk);
    b.amount = POS_W'(amt);
    b.avg_count = CNT_W'(cnt);
    return b;
  endfunction

  // Random beat: many pushes, queries mostly aimed inside the ring.
  function automatic in_t random_beat();
    in_t b;
    int ring;
    ring = ch_now * 128;
    b.sample = SAMPLE_W'($urandom_range(4095));
    b.op = ($urandom_range(99) < 35) ? OP_PUSH : OP_W'($urandom_range(7, 1));
    b.from_latest = 1'($urandom_range(1));
    b.position = POS_W'(($urandom_range(3) != 0) ? $urandom_range(ring - 1)
                                                 : $urandom_range(2047));
    b.amount = POS_W'(($urandom_range(4) != 0) ? $urandom_range(3 * ch_now)
                                               : $urandom_range(2047));
    b.rank = RANK_W'(($urandom_range(9) != 0) ? $urandom_range(ch_now + 1)
                                              : $urandom_range(31));
    b.avg_count = CNT_W'(($urandom_range(9) != 0) ? $urandom_range(8)
                                                  : $urandom_range(128));
    return b;
  endfunction

  initial begin
    in_t dir_q [$];
    int  ch_set [5];
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    hold_req = 0;
    tx_idle_pct = 31;
    rx_idle_pct = 57;
    ch_now = 3;
    ch_set = '{16, 1, 0, 31, 7};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    // Directed part at the reset setting of three channels.
    dir_q = '{
      make_beat(OP_RDNEXT, 0, 0, 0, 0, 0, 0),
      make_beat(OP_PUSH, 4095, 0, 0, 0, 0, 0),
      make_beat(OP_PUSH, 0, 0, 0, 0, 0, 0),
      make_beat(OP_PUSH, 12'hAAA, 0, 0, 0, 0, 0),
      make_beat(OP_PUSH, 12'h555, 0, 0, 0, 0, 0),
      make_beat(OP_COUNT, 0, 0, 0, 0, 0, 0),
      make_beat(OP_RDNEXT, 0, 0, 0, 0, 0, 0),
      make_beat(OP_SKIP, 0, 0, 0, 0, 0, 0),
      make_beat(OP_SKIP, 0, 0, 0, 0, 2047, 0),
      make_beat(OP_RDPOS, 0, 0, 0, 0, 0, 0),
      make_beat(OP_RDPOS, 0, 383, 0, 0, 0, 0),
      make_beat(OP_RDPOS, 0, 2047, 0, 0, 0, 0),
      make_beat(OP_FIND, 0, 0, 1, 1, 0, 0),
      make_beat(OP_FIND, 0, 5, 0, 0, 2, 0),
      make_beat(OP_FIND, 0, 5, 0, 4, 2, 0),
      make_beat(OP_FIND, 0, 0, 0, 3, 2047, 0),
      make_beat(OP_AVG, 0, 0, 1, 2, 0, 0),
      make_beat(OP_AVG, 0, 2, 0, 2, 0, 128),
      make_beat(OP_AVG, 0, 2047, 0, 31, 0, 255),
      make_beat(OP_AVG, 0, 1000, 0, 0, 0, 0),
      make_beat(OP_RDBACK, 0, 0, 0, 0, 1, 0),
      make_beat(OP_RDBACK, 0, 2047, 0, 16, 0, 0),
      make_beat(OP_RDBACK, 0, 10, 1, 0, 2047, 0)
    };
    foreach (dir_q[i]) send_beat(dir_q[i]);
    drain();

    // Random phases, each after a fresh write of the channels register.
    foreach (ch_set[p]) begin
      write_channels(ch_set[p]);
      if (p < 2) begin
        tx_idle_pct = 31;
        rx_idle_pct = 57;
      end else if (p < 4) begin
        tx_idle_pct = 57;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req++;
      end
      repeat (76) send_beat(random_beat());
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ssr_pkg.sv
rtl/ssr_div.sv
rtl/ssr_ctrl.sv
rtl/ssr_dp.sv
rtl/scan_sample_ring_with_rank_average.sv
tb/sv/ssr_checker.sv
tb/sv/tb.sv
